@@ hw/rtl/bounded_stack_with_min_defines.svh @@
// ------------------------------------------------------------------------
// Assertion macros for the min-tracking stack
// Shared property forms, clocked on the rising edge, held off in reset.
// ------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_MIN_DEFINES_SVH
`define BOUNDED_STACK_WITH_MIN_DEFINES_SVH

// same-cycle implication
`define BSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bsm_pkg.sv @@
// ------------------------------------------------------------------------
// bsm_pkg
// Types and codes shared by the min-tracking stack modules.
// ------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_QUERY = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    localparam logic signed [31:0] WORD_NEG_ONE = 32'shFFFF_FFFF;

    // first member in the highest bits: popped_word lands in bits [31:0]
    typedef struct packed {
        logic [4:0]         pad;
        t_err               error_code;
        logic [6:0]         fill_level;
        logic               is_full;
        logic               is_empty;
        logic signed [31:0] min_word;
        logic signed [31:0] top_word;
        logic signed [31:0] popped_word;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/bsm_store.sv @@
// ------------------------------------------------------------------------
// bsm_store
// Word and running-minimum memories below the top of stack, one write
// port and one registered read port.
// ------------------------------------------------------------------------
`default_nettype none

module bsm_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  wire [AW-1:0]         i_wr_addr,
    input  wire signed [31:0]    i_wr_word,
    input  wire signed [31:0]    i_wr_min,
    input  wire                  i_rd_en,
    input  wire [AW-1:0]         i_rd_addr,
    output logic signed [31:0]   o_rd_word,
    output logic signed [31:0]   o_rd_min
);

    logic signed [31:0] r_word_mem [DEPTH];
    logic signed [31:0] r_min_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_word_mem[i_wr_addr] <= i_wr_word;
            r_min_mem[i_wr_addr]  <= i_wr_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_word <= r_word_mem[i_rd_addr];
            o_rd_min  <= r_min_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bsm_out_q.sv @@
// ------------------------------------------------------------------------
// bsm_out_q
// Two-entry result queue between the stack core and the output channel.
// ------------------------------------------------------------------------
`default_nettype none

module bsm_out_q (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_wr_valid,
    input  bsm_pkg::t_result  i_wr_data,
    output logic              o_full,
    output logic              o_rd_valid,
    output bsm_pkg::t_result  o_rd_data,
    input  wire               i_rd_ready
);

    bsm_pkg::t_result r_ent [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             w_pop;

    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_full     = (r_cnt == 2'd2);
    assign o_rd_data  = r_ent[r_rptr];
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (i_wr_valid) begin
            r_ent[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_wr_valid) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_wr_valid, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bounded_stack_with_min.sv @@
// ------------------------------------------------------------------------
// bounded_stack_with_min
// Bounded LIFO of signed words with a running minimum kept per level.
//
// Input beat: tuser selects push, pop or query, tdata carries the word.
// Every input beat yields one output beat with the popped word, top,
// minimum, empty and full flags, fill level and error code.
// Top of stack and its minimum sit in registers; lower levels live in two
// memories, each with one write port and one registered read port.
// Push, query and pops that leave the stack empty: the result is queued at
// the accepting edge; a new beat is taken every cycle while the result
// queue has room.
// Pop leaving one or more words: the result waits in ST_POP for the memory
// read of the new top; tready drops while in ST_POP.
// Reset: level returns to zero; memories are not cleared, entries are
// only read after being written.
// Receiver stall: a two-entry result queue absorbs results; tready also
// drops while the queue is full.
// ------------------------------------------------------------------------
`default_nettype none

`include "bounded_stack_with_min_defines.svh"

module bounded_stack_with_min #(
    parameter int DEPTH = 64
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_s_tvalid,
    output logic          o_s_tready,
    input  wire [31:0]    i_s_tdata,   // value[31:0]
    input  wire [1:0]     i_s_tuser,   // func[1:0]
    output logic          o_m_tvalid,
    input  wire           i_m_tready,
    // popped_word[31:0], top_word[63:32], min_word[95:64], is_empty[96],
    // is_full[97], fill_level[104:98], error_code[106:105], zero[111:107]
    output logic [111:0]  o_m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [LW-1:0]      r_level, n_level;
    logic signed [31:0] r_top, n_top;
    logic signed [31:0] r_min, n_min;
    logic signed [31:0] r_popped, n_popped;

    logic               w_accept;
    logic               w_q_full;
    logic               w_wr_en;
    logic               w_rd_en;
    logic [LW-1:0]      w_lvl_m1;
    logic [LW-1:0]      w_lvl_m2;
    logic signed [31:0] w_val;
    logic signed [31:0] w_rd_word;
    logic signed [31:0] w_rd_min;
    logic               w_res_valid;
    logic signed [31:0] w_res_popped;
    bsm_pkg::t_err      w_res_err;
    logic [LW+6:0]      w_lvl_ext;
    bsm_pkg::t_result   w_res;
    bsm_pkg::t_result   w_q_data;

    assign o_s_tready = (r_state == ST_IDLE) && !w_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_val      = $signed(i_s_tdata);
    assign w_lvl_m1   = r_level - 1'b1;
    assign w_lvl_m2   = r_level - 2'd2;

    always_comb begin
        n_state      = r_state;
        n_level      = r_level;
        n_top        = r_top;
        n_min        = r_min;
        n_popped     = r_popped;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;
        w_res_valid  = 1'b0;
        w_res_popped = bsm_pkg::WORD_NEG_ONE;
        w_res_err    = bsm_pkg::ERR_NONE;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_res_valid = 1'b1;
                    case (i_s_tuser)
                        bsm_pkg::FUNC_PUSH: begin
                            if (r_level == LW'(DEPTH)) begin
                                w_res_err = bsm_pkg::ERR_FULL;
                            end else begin
                                w_wr_en = (r_level != '0);
                                n_top   = w_val;
                                n_min   = ((r_level != '0) && (r_min < w_val)) ? r_min : w_val;
                                n_level = r_level + 1'b1;
                            end
                        end
                        bsm_pkg::FUNC_POP: begin
                            if (r_level == '0) begin
                                w_res_err = bsm_pkg::ERR_EMPTY;
                            end else begin
                                w_res_popped = r_top;
                                n_level      = w_lvl_m1;
                                if (w_lvl_m1 != '0) begin
                                    w_rd_en     = 1'b1;
                                    n_popped    = r_top;
                                    n_state     = ST_POP;
                                    w_res_valid = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_top        = w_rd_word;
                n_min        = w_rd_min;
                w_res_popped = r_popped;
                w_res_valid  = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_lvl_ext = {7'd0, n_level};

    always_comb begin
        w_res             = '0;
        w_res.popped_word = w_res_popped;
        w_res.is_empty    = (n_level == '0);
        w_res.is_full     = (n_level == LW'(DEPTH));
        w_res.top_word    = w_res.is_empty ? bsm_pkg::WORD_NEG_ONE : n_top;
        w_res.min_word    = w_res.is_empty ? bsm_pkg::WORD_NEG_ONE : n_min;
        w_res.fill_level  = w_lvl_ext[6:0];
        w_res.error_code  = w_res_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_level <= '0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_min    <= n_min;
        r_popped <= n_popped;
    end

    bsm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_lvl_m1[AW-1:0]),
        .i_wr_word (r_top),
        .i_wr_min  (r_min),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_lvl_m2[AW-1:0]),
        .o_rd_word (w_rd_word),
        .o_rd_min  (w_rd_min)
    );

    bsm_out_q u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_res_valid),
        .i_wr_data  (w_res),
        .o_full     (w_q_full),
        .o_rd_valid (o_m_tvalid),
        .o_rd_data  (w_q_data),
        .i_rd_ready (i_m_tready)
    );

    assign o_m_tdata = w_q_data;

    `BSM_ASSERT_NEXT(a_pop_waits_read, i_clk, i_rst_n,
        w_accept && (i_s_tuser == bsm_pkg::FUNC_POP) && (r_level > LW'(1)),
        (r_state == ST_POP) && !o_s_tready, "deep pop did not wait for memory read")
    `BSM_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n,
        w_accept && (i_s_tuser == bsm_pkg::FUNC_PUSH) && (r_level != LW'(DEPTH)),
        r_level == $past(r_level) + 1'b1, "accepted push did not raise level")
    `BSM_ASSERT_NOW(a_level_bound, i_clk, i_rst_n, 1'b1,
        r_level <= LW'(DEPTH), "level above depth")

endmodule

`default_nettype wire
